[hw/rtl/dpx_pkg.sv]
// shared constants for the depth pixel to xyz back-projection core
package dpx_pkg;

  localparam int INDEX_BITS_DEFAULT = 12;

  localparam int DEPTH_W   = 16;
  localparam int CENTER_W  = 16;
  localparam int SCALE_W   = 32;
  localparam int COORD_W   = 32;
  localparam int Z_W       = 31;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PRINC_COL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINC_ROW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;

  localparam logic [CENTER_W-1:0] PRINC_COL_RESET   = 16'd5120;
  localparam logic [CENTER_W-1:0] PRINC_ROW_RESET   = 16'd3840;
  localparam logic [SCALE_W-1:0]  SCALE_X_RESET     = 32'd8181;
  localparam logic [SCALE_W-1:0]  SCALE_Y_RESET     = 32'd8181;
  localparam logic [SCALE_W-1:0]  DEPTH_SCALE_RESET = 32'd4294967;

  // output tdata: point_x, point_y, point_z, one pad bit
  localparam int OUT_W       = 2 * COORD_W + Z_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

[hw/rtl/depth_pixel_to_xyz_core.sv]
// pinhole back-projection of one depth pixel to a saturated xyz point
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: depth_raw, pixel_column, pixel_row
//  m_*       out  m_tvalid/m_tready  m_tdata: point_x, point_y, point_z; m_tuser: valid
//  cfg_*     in   cfg_write          cfg_index, cfg_data
//
// five register stages: offset, depth product, scale products, sum, saturate.
// one item per cycle sustained while m_tready is high.
// the multiplier stages set the rate; each holds at most a 32x16 product.
// rst clears all stage valid bits and loads the register reset values.
// a stall on m_tready holds the full stages from the output back to the first empty one; empty stages still fill.
module depth_pixel_to_xyz_core #(
  parameter int INDEX_BITS = dpx_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dpx_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dpx_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // depth_raw, pixel_column, pixel_row, zero fill
  input  logic [((dpx_pkg::DEPTH_W + 2*INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // point_x, point_y, point_z, zero fill
  output logic [dpx_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // point_valid
  output logic [0:0]                            m_tuser
);

  localparam int POS_W  = INDEX_BITS + 4;
  localparam int DIFF_W = (POS_W > dpx_pkg::CENTER_W) ? POS_W : dpx_pkg::CENTER_W;
  localparam int P_W    = DIFF_W + dpx_pkg::DEPTH_W;
  localparam int A_W    = P_W + 16;
  localparam int S_W    = A_W + 1;
  localparam int Q_W    = S_W - 4;
  localparam int ZP_W   = dpx_pkg::DEPTH_W + dpx_pkg::SCALE_W;
  localparam int C_W    = dpx_pkg::COORD_W;

  // configuration registers
  logic [dpx_pkg::CENTER_W-1:0] princ_col, princ_row;
  logic [dpx_pkg::SCALE_W-1:0]  scale_x, scale_y, depth_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      princ_col   <= dpx_pkg::PRINC_COL_RESET;
      princ_row   <= dpx_pkg::PRINC_ROW_RESET;
      scale_x     <= dpx_pkg::SCALE_X_RESET;
      scale_y     <= dpx_pkg::SCALE_Y_RESET;
      depth_scale <= dpx_pkg::DEPTH_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dpx_pkg::REG_PRINC_COL:   princ_col   <= cfg_data[dpx_pkg::CENTER_W-1:0];
        dpx_pkg::REG_PRINC_ROW:   princ_row   <= cfg_data[dpx_pkg::CENTER_W-1:0];
        dpx_pkg::REG_SCALE_X:     scale_x     <= cfg_data[dpx_pkg::SCALE_W-1:0];
        dpx_pkg::REG_SCALE_Y:     scale_y     <= cfg_data[dpx_pkg::SCALE_W-1:0];
        dpx_pkg::REG_DEPTH_SCALE: depth_scale <= cfg_data[dpx_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [dpx_pkg::DEPTH_W-1:0] in_depth;
  logic [INDEX_BITS-1:0]       in_col, in_row;

  assign in_depth = s_tdata[dpx_pkg::DEPTH_W-1:0];
  assign in_col   = s_tdata[dpx_pkg::DEPTH_W +: INDEX_BITS];
  assign in_row   = s_tdata[dpx_pkg::DEPTH_W + INDEX_BITS +: INDEX_BITS];

  // stage valids and load enables, en[k] lets stage k take new data
  logic [5:1] vld;
  logic [6:1] en;

  always_comb begin
    en[6] = m_tready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end
  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: signed offset from the principal point, as sign and magnitude
  logic [DIFF_W-1:0]           pos_x, pos_y, cen_x, cen_y;
  logic [DIFF_W-1:0]           diff_x_next, diff_y_next;
  logic                        neg_x_next, neg_y_next;

  assign pos_x = DIFF_W'({in_col, 4'b0000});
  assign pos_y = DIFF_W'({in_row, 4'b0000});
  assign cen_x = DIFF_W'(princ_col);
  assign cen_y = DIFF_W'(princ_row);

  always_comb begin
    neg_x_next  = cen_x > pos_x;
    neg_y_next  = cen_y > pos_y;
    diff_x_next = neg_x_next ? (cen_x - pos_x) : (pos_x - cen_x);
    diff_y_next = neg_y_next ? (cen_y - pos_y) : (pos_y - cen_y);
  end

  logic [DIFF_W-1:0]           s1_diff_x, s1_diff_y;
  logic [dpx_pkg::DEPTH_W-1:0] s1_depth;
  logic [4:1]                  neg_x, neg_y;
  logic [5:1]                  pv;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_diff_x <= diff_x_next;
      s1_diff_y <= diff_y_next;
      s1_depth  <= in_depth;
      neg_x[1]  <= neg_x_next;
      neg_y[1]  <= neg_y_next;
      pv[1]     <= in_depth != '0;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        neg_x[k] <= neg_x[k-1];
        neg_y[k] <= neg_y[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) pv[k] <= pv[k-1];
    end
  end

  // stage 2: offset times depth, and depth times its scale
  logic [P_W-1:0]  s2_p_x, s2_p_y;
  logic [ZP_W-1:0] s2_zprod;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_p_x   <= P_W'(s1_diff_x) * P_W'(s1_depth);
      s2_p_y   <= P_W'(s1_diff_y) * P_W'(s1_depth);
      s2_zprod <= ZP_W'(s1_depth) * ZP_W'(depth_scale);
    end
  end

  // stage 3: multiply by the axis scale in two 16-bit halves, and saturate z
  logic [A_W-1:0]          s3_a_x, s3_b_x, s3_a_y, s3_b_y;
  logic [dpx_pkg::Z_W-1:0] s3_z, s4_z, s5_z;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_a_x <= A_W'(s2_p_x) * A_W'(scale_x[31:16]);
      s3_b_x <= A_W'(s2_p_x) * A_W'(scale_x[15:0]);
      s3_a_y <= A_W'(s2_p_y) * A_W'(scale_y[31:16]);
      s3_b_y <= A_W'(s2_p_y) * A_W'(scale_y[15:0]);
      s3_z   <= s2_zprod[ZP_W-1] ? '1 : s2_zprod[ZP_W-2:16];
    end
  end

  // stage 4: recombine halves, keep a sticky bit for the dropped fraction
  logic [S_W-1:0] sum_x, sum_y;
  logic [Q_W-1:0] s4_q_x, s4_q_y;
  logic           s4_rem_x, s4_rem_y;

  assign sum_x = S_W'(s3_a_x) + S_W'(s3_b_x[A_W-1:16]);
  assign sum_y = S_W'(s3_a_y) + S_W'(s3_b_y[A_W-1:16]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_q_x   <= sum_x[S_W-1:4];
      s4_q_y   <= sum_y[S_W-1:4];
      s4_rem_x <= (s3_b_x[15:0] != '0) || (sum_x[3:0] != '0);
      s4_rem_y <= (s3_b_y[15:0] != '0) || (sum_y[3:0] != '0);
      s4_z     <= s3_z;
    end
  end

  // stage 5: floor for negatives, saturate, apply sign
  function automatic logic [C_W-1:0] finish_axis(input logic [Q_W-1:0] q,
                                                 input logic           rem,
                                                 input logic           neg);
    logic [Q_W-1:0] qn;
    logic [C_W-1:0] mag;
    begin
      if (!neg) begin
        finish_axis = (q > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[C_W-1:0];
      end else begin
        qn  = q + Q_W'(rem);
        mag = (qn > Q_W'(32'h8000_0000)) ? 32'h8000_0000 : qn[C_W-1:0];
        finish_axis = 32'd0 - mag;
      end
    end
  endfunction

  logic [C_W-1:0] s5_x, s5_y;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_x <= finish_axis(s4_q_x, s4_rem_x, neg_x[4]);
      s5_y <= finish_axis(s4_q_y, s4_rem_y, neg_y[4]);
      s5_z <= s4_z;
    end
  end

  // missing point reads as all zeros
  assign m_tvalid = vld[5];
  assign m_tuser  = pv[5];
  assign m_tdata  = pv[5] ? dpx_pkg::OUT_TDATA_W'({s5_z, s5_y, s5_x}) : '0;

endmodule

[hw/rtl/dpx_checker.sv]
// port-level checks for the depth pixel to xyz core, bound to the top level
module dpx_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [dpx_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input logic [0:0]                            m_tuser
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output item changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // an empty output means nothing blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // a missing point carries zero coordinates
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("missing point with nonzero coordinates");

  // point_z never reaches bit 31 and the pad bit stays clear
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[dpx_pkg::OUT_TDATA_W-1 : dpx_pkg::OUT_W] == '0)
    else $error("pad bits of output set");

endmodule

bind depth_pixel_to_xyz_core dpx_checker u_dpx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[dv/testbench.sv]
// self-checking testbench for the depth pixel to xyz back-projection core
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH_W     = dpx_pkg::DEPTH_W;
  localparam int CENTER_W    = dpx_pkg::CENTER_W;
  localparam int SCALE_W     = dpx_pkg::SCALE_W;
  localparam int COORD_W     = dpx_pkg::COORD_W;
  localparam int Z_W         = dpx_pkg::Z_W;
  localparam int CFG_IDX_W   = dpx_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = dpx_pkg::CFG_DATA_W;
  localparam int OUT_W       = dpx_pkg::OUT_W;
  localparam int OUT_TDATA_W = dpx_pkg::OUT_TDATA_W;

  localparam int IDX_W     = dpx_pkg::INDEX_BITS_DEFAULT;
  localparam int S_TDATA_W = ((DEPTH_W + 2 * IDX_W + 7) / 8) * 8;
  localparam int LATENCY   = 5;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int PHASES    = 10;
  localparam int PHASE_ITEMS = 110;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [Z_W-1:0]            z;
    logic                      valid;
  } point_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  // camera calibration as the core should hold it
  logic [CENTER_W-1:0] cam_princ_col;
  logic [CENTER_W-1:0] cam_princ_row;
  logic [SCALE_W-1:0]  cam_scale_x;
  logic [SCALE_W-1:0]  cam_scale_y;
  logic [SCALE_W-1:0]  cam_depth_scale;

  point_t pending_points[$];

  bit send_gaps;
  bit recv_stalls;
  int n_errors;
  int n_pixels;
  int n_missing;
  int n_clamped;
  int n_settings;
  int cycle_count;

  always #2 clk = ~clk;

  depth_pixel_to_xyz_core #(.INDEX_BITS(IDX_W)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // floor(((idx*16 - center) * depth * scale) / 2^20), clamped to 32 bits signed
  function automatic logic [COORD_W-1:0] back_project(logic [IDX_W-1:0] idx,
      logic [CENTER_W-1:0] center, logic [DEPTH_W-1:0] depth, logic [SCALE_W-1:0] scale);
    logic signed [79:0] offs;
    logic signed [79:0] prod;
    logic signed [79:0] q;
    offs = $signed({64'd0, idx, 4'd0}) - $signed({64'd0, center});
    prod = offs * $signed({64'd0, depth}) * $signed({48'd0, scale});
    q = prod >>> 20;
    if (q > 80'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -80'sd2147483648) return 32'h8000_0000;
    return q[COORD_W-1:0];
  endfunction

  function automatic point_t predict_point(logic [DEPTH_W-1:0] depth,
      logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    point_t p;
    logic [47:0] zp;
    logic [31:0] zq;
    p = '{x: '0, y: '0, z: '0, valid: 1'b0};
    if (depth != 0) begin
      zp = depth * cam_depth_scale;
      zq = zp[47:16];
      p.z = (zq > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : zq[Z_W-1:0];
      p.x = back_project(col, cam_princ_col, depth, cam_scale_x);
      p.y = back_project(row, cam_princ_row, depth, cam_scale_y);
      p.valid = 1'b1;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < 30)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic int gap_len(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // result checker
  always @(posedge clk) begin
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[COORD_W-1:0] !== want.x)
          report_mismatch("point_x", m_tdata[COORD_W-1:0], want.x);
        if (m_tdata[2*COORD_W-1:COORD_W] !== want.y)
          report_mismatch("point_y", m_tdata[2*COORD_W-1:COORD_W], want.y);
        if (m_tdata[2*COORD_W+Z_W-1:2*COORD_W] !== want.z)
          report_mismatch("point_z", {1'b0, m_tdata[2*COORD_W+Z_W-1:2*COORD_W]},
                          {1'b0, want.z});
        if (m_tdata[OUT_TDATA_W-1:OUT_W] !== '0)
          report_mismatch("tdata fill", {31'd0, m_tdata[OUT_TDATA_W-1]}, '0);
        if (m_tuser[0] !== want.valid)
          report_mismatch("point_valid", {31'd0, m_tuser[0]}, {31'd0, want.valid});
        if (want.x == 32'h7FFF_FFFF || want.x == 32'h8000_0000 ||
            want.y == 32'h7FFF_FFFF || want.y == 32'h8000_0000)
          n_clamped++;
      end
    end
  end

  // output back-pressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stalls && $urandom_range(0, 99) < 30) begin
        m_tready <= 1'b0;
        repeat (gap_len(1'b1) + 1) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_points.size());
      $display("FAIL depth_pixel_to_xyz_core");
      $finish;
    end
  end

  task automatic send_pixel(logic [DEPTH_W-1:0] depth, logic [IDX_W-1:0] col,
      logic [IDX_W-1:0] row);
    int gap;
    logic [S_TDATA_W-1:0] word;
    gap = gap_len(send_gaps);
    word = '0;
    word[DEPTH_W-1:0] = depth;
    word[DEPTH_W+IDX_W-1:DEPTH_W] = col;
    word[DEPTH_W+2*IDX_W-1:DEPTH_W+IDX_W] = row;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_points.push_back(predict_point(depth, col, row));
    n_pixels++;
    if (depth == 0) n_missing++;
  endtask

  // stop sending and wait for every outstanding point
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drain();
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      dpx_pkg::REG_PRINC_COL:   cam_princ_col = data[CENTER_W-1:0];
      dpx_pkg::REG_PRINC_ROW:   cam_princ_row = data[CENTER_W-1:0];
      dpx_pkg::REG_SCALE_X:     cam_scale_x = data;
      dpx_pkg::REG_SCALE_Y:     cam_scale_y = data;
      dpx_pkg::REG_DEPTH_SCALE: cam_depth_scale = data;
      default: ;
    endcase
  endtask

  // upper bits of the center writes carry junk that must be dropped
  task automatic set_calibration(logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
      logic [SCALE_W-1:0] sx, logic [SCALE_W-1:0] sy, logic [SCALE_W-1:0] ds);
    wait_idle();
    write_reg(dpx_pkg::REG_PRINC_COL, {16'($urandom()), cx});
    write_reg(dpx_pkg::REG_PRINC_ROW, {16'($urandom()), cy});
    write_reg(dpx_pkg::REG_SCALE_X, sx);
    write_reg(dpx_pkg::REG_SCALE_Y, sy);
    write_reg(dpx_pkg::REG_DEPTH_SCALE, ds);
    n_settings++;
  endtask

  function automatic logic [SCALE_W-1:0] rand_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return $urandom_range(1, 65535);
    return $urandom();
  endfunction

  task automatic test_directed_extremes();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    // reset calibration: missing points, corners, pixel on the principal point
    send_pixel(16'd0, 12'd4095, 12'd4095);
    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'd65535, 12'd4095, 12'd4095);
    send_pixel(16'd65535, 12'd0, 12'd0);
    send_pixel(16'd1234, 12'd320, 12'd240);
    send_pixel(16'd40000, 12'd319, 12'd241);
    // maximal scales with the center at the origin: positive clamp, z clamp
    set_calibration(16'd0, 16'd0, '1, '1, '1);
    send_pixel(16'd65535, 12'd4095, 12'd4095);
    send_pixel(16'd1, 12'd1, 12'd1);
    send_pixel(16'd65535, 12'd0, 12'd0);
    // center past the last column: negative clamp and floor rounding
    set_calibration(16'hFFFF, 16'hFFFF, '1, '1, '1);
    send_pixel(16'd65535, 12'd0, 12'd0);
    send_pixel(16'd65535, 12'd4095, 12'd4095);
    send_pixel(16'd1, 12'd4095, 12'd0);
    send_pixel(16'd0, 12'd123, 12'd456);
    // zero scales still give a valid point at the origin
    set_calibration(16'hFFFF, 16'd0, '0, '0, '0);
    send_pixel(16'd65535, 12'd4095, 12'd4095);
    send_pixel(16'd7, 12'd0, 12'd4095);
  endtask

  task automatic test_unused_registers();
    set_calibration(dpx_pkg::PRINC_COL_RESET, dpx_pkg::PRINC_ROW_RESET,
                    dpx_pkg::SCALE_X_RESET, dpx_pkg::SCALE_Y_RESET,
                    dpx_pkg::DEPTH_SCALE_RESET);
    // writes above the last register index must leave the calibration alone
    for (int i = int'(dpx_pkg::REG_DEPTH_SCALE) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom());
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    for (int i = 0; i < 6; i++)
      send_pixel(16'($urandom_range(1, 65535)), 12'($urandom()), 12'($urandom()));
  endtask

  task automatic test_random_stream();
    int r;
    int pause_at;
    logic [DEPTH_W-1:0] depth;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_calibration(dpx_pkg::PRINC_COL_RESET, dpx_pkg::PRINC_ROW_RESET,
                           dpx_pkg::SCALE_X_RESET, dpx_pkg::SCALE_Y_RESET,
                           dpx_pkg::DEPTH_SCALE_RESET);
        1: set_calibration(16'd0, 16'd0, '1, '1, '1);
        2: set_calibration(16'hFFFF, 16'hFFFF, '0, '0, '0);
        default: set_calibration(16'($urandom()), 16'($urandom()), rand_scale(),
                                 rand_scale(), rand_scale());
      endcase
      case (ph % 3)
        0: begin send_gaps = 1'b0; recv_stalls = 1'b0; end
        1: begin send_gaps = 1'b1; recv_stalls = 1'b1; end
        default: begin send_gaps = $urandom_range(0, 1); recv_stalls = !send_gaps; end
      endcase
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) wait_drain();
        r = $urandom_range(0, 99);
        if (r < 6) depth = '0;
        else if (r < 15) depth = $urandom_range(1, 15);
        else if (r < 25) depth = $urandom_range(65000, 65535);
        else depth = $urandom_range(1, 65535);
        col = ($urandom_range(0, 9) == 0) ? {IDX_W{$urandom_range(0, 1) == 1}} :
              IDX_W'($urandom());
        row = ($urandom_range(0, 9) == 0) ? {IDX_W{$urandom_range(0, 1) == 1}} :
              IDX_W'($urandom());
        send_pixel(depth, col, row);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cam_princ_col = dpx_pkg::PRINC_COL_RESET;
    cam_princ_row = dpx_pkg::PRINC_ROW_RESET;
    cam_scale_x = dpx_pkg::SCALE_X_RESET;
    cam_scale_y = dpx_pkg::SCALE_Y_RESET;
    cam_depth_scale = dpx_pkg::DEPTH_SCALE_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_unused_registers();
    test_random_stream();

    wait_drain();
    repeat (4 * LATENCY) @(posedge clk);
    $display("sent %0d pixels, %0d of them missing, under %0d calibrations",
             n_pixels, n_missing, n_settings);
    $display("%0d points had a clamped x or y; %0d mismatches", n_clamped, n_errors);
    if (n_errors == 0) begin
      $display("PASS depth_pixel_to_xyz_core");
    end else begin
      $display("FAIL depth_pixel_to_xyz_core");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dpx_pkg.sv
hw/rtl/depth_pixel_to_xyz_core.sv
hw/rtl/dpx_checker.sv
dv/testbench.sv
